[rtl/marq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// marq_pkg
// Types and constants shared by the two-line marquee scroll sequencer.
// ----------------------------------------------------------------------------
package marq_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int TICK_BITS  = 16;
  localparam int IDX_BITS   = 2;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_STOP = 2'd2;

  localparam logic [IDX_BITS-1:0] REG_DISPLAY_WIDTH = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_PAUSE_TICKS   = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_SUBJ_STEP     = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_SEND_STEP     = 2'd3;

  localparam logic [PIXEL_BITS-1:0] DISPLAY_WIDTH_RST = 12'd128;
  localparam logic [TICK_BITS-1:0]  PAUSE_TICKS_RST   = 16'd500;
  localparam logic [TICK_BITS-1:0]  SUBJ_STEP_RST     = 16'd50;
  localparam logic [TICK_BITS-1:0]  SEND_STEP_RST     = 16'd100;

  typedef enum logic [2:0] {
    PH_OFF         = 3'd0,
    PH_HOLD        = 3'd1,
    PH_SUBJ_PAUSE  = 3'd2,
    PH_SUBJ_SCROLL = 3'd3,
    PH_SEND_PAUSE  = 3'd4,
    PH_SEND_SCROLL = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [PIXEL_BITS-1:0] sender_width;
    logic [PIXEL_BITS-1:0] subject_width;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] sender_offset;
    logic [PIXEL_BITS-1:0] subject_offset;
    logic                  redraw;
    logic [2:0]            phase;
  } out_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] display_width;
    logic [TICK_BITS-1:0]  pause_ticks;
    logic [TICK_BITS-1:0]  subject_step_ticks;
    logic [TICK_BITS-1:0]  sender_step_ticks;
  } cfg_regs_t;

endpackage
`default_nettype wire

[rtl/marq_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// marq_cfg_regs
// Configuration register file, one write per cycle, always ready.
// ----------------------------------------------------------------------------
module marq_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire logic [marq_pkg::IDX_BITS-1:0] wr_index,
  input  wire logic [marq_pkg::TICK_BITS-1:0] wr_data,
  output marq_pkg::cfg_regs_t                cfg
);
  import marq_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_DISPLAY_WIDTH: cfg_nxt.display_width      = wr_data[PIXEL_BITS-1:0];
        REG_PAUSE_TICKS:   cfg_nxt.pause_ticks        = wr_data;
        REG_SUBJ_STEP:     cfg_nxt.subject_step_ticks = wr_data;
        REG_SEND_STEP:     cfg_nxt.sender_step_ticks  = wr_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_width      <= DISPLAY_WIDTH_RST;
      cfg_r.pause_ticks        <= PAUSE_TICKS_RST;
      cfg_r.subject_step_ticks <= SUBJ_STEP_RST;
      cfg_r.sender_step_ticks  <= SEND_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/marq_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// marq_core
// Scroll state and phase sequencer; updates once per processed word.
// ----------------------------------------------------------------------------
module marq_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  marq_pkg::in_item_t       item,
  input  marq_pkg::cfg_regs_t      cfg,
  output marq_pkg::out_item_t      res
);
  import marq_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [TICK_BITS-1:0]  elapsed_r, elapsed_nxt;
  logic [PIXEL_BITS-1:0] send_shift_r, send_shift_nxt;
  logic [PIXEL_BITS-1:0] subj_shift_r, subj_shift_nxt;
  logic [PIXEL_BITS-1:0] send_len_r, send_len_nxt;
  logic [PIXEL_BITS-1:0] subj_len_r, subj_len_nxt;
  logic                  redraw;

  logic [TICK_BITS-1:0]  elapsed_inc;
  logic [PIXEL_BITS:0]   send_next, subj_next;
  logic                  send_wide, subj_wide;
  logic                  ld_send_wide, ld_subj_wide;
  logic                  pause_done, subj_step_done, send_step_done;
  logic                  subj_wrap, send_wrap;

  assign elapsed_inc    = (elapsed_r == {TICK_BITS{1'b1}}) ? elapsed_r
                                                           : elapsed_r + 1'b1;
  assign send_next      = {1'b0, send_shift_r} + 1'b1;
  assign subj_next      = {1'b0, subj_shift_r} + 1'b1;
  assign send_wrap      = send_next > {1'b0, send_len_r};
  assign subj_wrap      = subj_next > {1'b0, subj_len_r};
  assign send_wide      = send_len_r > cfg.display_width;
  assign subj_wide      = subj_len_r > cfg.display_width;
  assign ld_send_wide   = item.sender_width > cfg.display_width;
  assign ld_subj_wide   = item.subject_width > cfg.display_width;
  assign pause_done     = elapsed_inc >= cfg.pause_ticks;
  assign subj_step_done = elapsed_inc >= cfg.subject_step_ticks;
  assign send_step_done = elapsed_inc >= cfg.sender_step_ticks;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (item.op)
      OP_LOAD: begin
        if (ld_subj_wide)      phase_nxt = PH_SUBJ_PAUSE;
        else if (ld_send_wide) phase_nxt = PH_SEND_PAUSE;
        else                   phase_nxt = PH_HOLD;
      end
      OP_TICK: begin
        case (phase_r)
          PH_SUBJ_PAUSE: if (pause_done) phase_nxt = PH_SUBJ_SCROLL;
          PH_SEND_PAUSE: if (pause_done) phase_nxt = PH_SEND_SCROLL;
          PH_SUBJ_SCROLL: begin
            if (subj_step_done && subj_wrap)
              phase_nxt = send_wide ? PH_SEND_PAUSE : PH_SUBJ_PAUSE;
          end
          PH_SEND_SCROLL: begin
            if (send_step_done && send_wrap)
              phase_nxt = subj_wide ? PH_SUBJ_PAUSE : PH_SEND_PAUSE;
          end
          default: phase_nxt = phase_r;
        endcase
      end
      OP_STOP: phase_nxt = PH_OFF;
      default: phase_nxt = phase_r;
    endcase
  end

  // counters, offsets and redraw
  always_comb begin
    elapsed_nxt    = elapsed_r;
    send_shift_nxt = send_shift_r;
    subj_shift_nxt = subj_shift_r;
    send_len_nxt   = send_len_r;
    subj_len_nxt   = subj_len_r;
    redraw         = 1'b0;
    case (item.op)
      OP_LOAD: begin
        send_len_nxt   = item.sender_width;
        subj_len_nxt   = item.subject_width;
        send_shift_nxt = '0;
        subj_shift_nxt = '0;
        elapsed_nxt    = '0;
        redraw         = 1'b1;
      end
      OP_TICK: begin
        elapsed_nxt = elapsed_inc;
        case (phase_r)
          PH_SUBJ_PAUSE, PH_SEND_PAUSE: begin
            if (pause_done) elapsed_nxt = '0;
          end
          PH_SUBJ_SCROLL: begin
            if (subj_step_done) begin
              elapsed_nxt    = '0;
              redraw         = 1'b1;
              subj_shift_nxt = subj_wrap ? '0 : subj_next[PIXEL_BITS-1:0];
            end
          end
          PH_SEND_SCROLL: begin
            if (send_step_done) begin
              elapsed_nxt    = '0;
              redraw         = 1'b1;
              send_shift_nxt = send_wrap ? '0 : send_next[PIXEL_BITS-1:0];
            end
          end
          default: elapsed_nxt = elapsed_inc;
        endcase
      end
      default: redraw = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OFF;
      elapsed_r    <= '0;
      send_shift_r <= '0;
      subj_shift_r <= '0;
      send_len_r   <= '0;
      subj_len_r   <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      elapsed_r    <= elapsed_nxt;
      send_shift_r <= send_shift_nxt;
      subj_shift_r <= subj_shift_nxt;
      send_len_r   <= send_len_nxt;
      subj_len_r   <= subj_len_nxt;
    end
  end

  assign res.sender_offset  = send_shift_nxt;
  assign res.subject_offset = subj_shift_nxt;
  assign res.redraw         = redraw;
  assign res.phase          = phase_nxt;

endmodule
`default_nettype wire

[rtl/two_line_marquee_scroll_sequencer_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_line_marquee_scroll_sequencer_top
// Scroll sequencer for a two-line marquee: load, tick and stop words in,
// line offsets, redraw flag and phase out.
// ----------------------------------------------------------------------------
// One result word per input word, in order. A word is taken into an input
// register, processed against the scroll state once the output register is
// free or being emptied and placed there; the result stays on out_valid until
// an edge with out_stall low takes it. One word per cycle is sustained while
// out_stall is low; the input and output registers let a new word enter while
// a finished result waits on out_stall. Configuration writes are always ready
// and take effect on the next word processed.
// ----------------------------------------------------------------------------
module two_line_marquee_scroll_sequencer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  marq_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output marq_pkg::out_item_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [marq_pkg::IDX_BITS-1:0]  cfg_index,
  input  wire logic [marq_pkg::TICK_BITS-1:0] cfg_data
);
  import marq_pkg::*;

  cfg_regs_t cfg;
  in_item_t  in_data_r;
  out_item_t out_data_r;
  out_item_t res;
  logic      in_vld_r, in_vld_nxt;
  logic      out_vld_r, out_vld_nxt;
  logic      advance, fire, in_take;

  assign cfg_ready = 1'b1;

  marq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  marq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take)   in_vld_nxt = 1'b1;
    else if (fire) in_vld_nxt = 1'b0;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (fire)         out_vld_nxt = 1'b1;
    else if (advance) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_data_r <= in_data;
    if (fire)    out_data_r <= res;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench for the two-line marquee scroll sequencer.
// ----------------------------------------------------------------------------
// A driver streams load, tick, stop and unused-op words from a queue and a
// monitor checks every result word against a scroll-state predictor kept
// in the bench. The run walks through the reset settings, both register
// extremes and a set of random settings, including offset wraps on both
// lines. Random gaps are inserted on both channels, and one long output
// hold-off backs up the pipe into the input stall.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import marq_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         HOLD_CYCLES = 250;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IDX_BITS-1:0]  cfg_index = '0;
  logic [TICK_BITS-1:0] cfg_data  = '0;

  two_line_marquee_scroll_sequencer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predicted scroll state and register copies
  logic [PIXEL_BITS-1:0] cur_width    = DISPLAY_WIDTH_RST;
  logic [TICK_BITS-1:0]  cur_pause    = PAUSE_TICKS_RST;
  logic [TICK_BITS-1:0]  cur_bot_step = SUBJ_STEP_RST;
  logic [TICK_BITS-1:0]  cur_top_step = SEND_STEP_RST;
  phase_t                ph           = PH_OFF;
  logic [TICK_BITS-1:0]  tick_count   = '0;
  logic [PIXEL_BITS-1:0] top_shift    = '0;
  logic [PIXEL_BITS-1:0] bot_shift    = '0;
  logic [PIXEL_BITS-1:0] top_len      = '0;
  logic [PIXEL_BITS-1:0] bot_len      = '0;

  in_item_t  pending_words[$];
  out_item_t expected_frames[$];

  int  error_count  = 0;
  int  words_taken  = 0;
  int  frames_seen  = 0;
  int  load_count   = 0;
  int  wrap_count   = 0;
  int  cycle_count  = 0;
  int  send_gap     = 0;
  int  recv_gap     = 0;
  bit  send_idle_en = 1'b1;
  bit  recv_idle_en = 1'b1;
  bit  hold_go      = 1'b0;
  bit  hold_on      = 1'b0;

  function automatic out_item_t compute_frame(in_item_t w);
    logic [PIXEL_BITS:0] nxt;
    logic                draw;
    out_item_t           r;
    draw = 1'b0;
    case (w.op)
      OP_LOAD: begin
        top_len    = w.sender_width;
        bot_len    = w.subject_width;
        top_shift  = '0;
        bot_shift  = '0;
        tick_count = '0;
        if (bot_len > cur_width) ph = PH_SUBJ_PAUSE;
        else if (top_len > cur_width) ph = PH_SEND_PAUSE;
        else ph = PH_HOLD;
        draw = 1'b1;
        load_count++;
      end
      OP_TICK: begin
        if (tick_count != '1) tick_count = tick_count + 1'b1;
        case (ph)
          PH_SUBJ_PAUSE: begin
            if (tick_count >= cur_pause) begin
              ph         = PH_SUBJ_SCROLL;
              tick_count = '0;
            end
          end
          PH_SEND_PAUSE: begin
            if (tick_count >= cur_pause) begin
              ph         = PH_SEND_SCROLL;
              tick_count = '0;
            end
          end
          PH_SUBJ_SCROLL: begin
            if (tick_count >= cur_bot_step) begin
              nxt        = {1'b0, bot_shift} + 1'b1;
              tick_count = '0;
              draw       = 1'b1;
              if (nxt > {1'b0, bot_len}) begin
                bot_shift = '0;
                ph = (top_len > cur_width) ? PH_SEND_PAUSE : PH_SUBJ_PAUSE;
                wrap_count++;
              end else begin
                bot_shift = nxt[PIXEL_BITS-1:0];
              end
            end
          end
          PH_SEND_SCROLL: begin
            if (tick_count >= cur_top_step) begin
              nxt        = {1'b0, top_shift} + 1'b1;
              tick_count = '0;
              draw       = 1'b1;
              if (nxt > {1'b0, top_len}) begin
                top_shift = '0;
                ph = (bot_len > cur_width) ? PH_SUBJ_PAUSE : PH_SEND_PAUSE;
                wrap_count++;
              end else begin
                top_shift = nxt[PIXEL_BITS-1:0];
              end
            end
          end
          default: ;
        endcase
      end
      OP_STOP: ph = PH_OFF;
      default: ;
    endcase
    r.sender_offset  = top_shift;
    r.subject_offset = bot_shift;
    r.redraw         = draw;
    r.phase          = ph;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH result %0d: %s", frames_seen, msg);
  endtask

  // input side: one word in flight, held until taken
  always @(posedge clk) begin : driver
    in_item_t nd;
    logic     nv;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_frames.push_back(compute_frame(in_data));
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        nv = 1'b0;
        nd = in_data;
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_words.size() != 0) begin
          nd = pending_words.pop_front();
          nv = 1'b1;
          if (send_idle_en && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 17);
        end
        in_valid <= nv;
        in_data  <= nd;
      end
    end
  end

  // output side: check taken results, then pick next stall
  always @(posedge clk) begin : monitor
    out_item_t want;
    logic      nst;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = expected_frames.pop_front();
        if (out_data.sender_offset !== want.sender_offset)
          report_mismatch($sformatf("sender_offset got %0d expected %0d",
                                    out_data.sender_offset, want.sender_offset));
        if (out_data.subject_offset !== want.subject_offset)
          report_mismatch($sformatf("subject_offset got %0d expected %0d",
                                    out_data.subject_offset, want.subject_offset));
        if (out_data.redraw !== want.redraw)
          report_mismatch($sformatf("redraw got %0b expected %0b",
                                    out_data.redraw, want.redraw));
        if (out_data.phase !== want.phase)
          report_mismatch($sformatf("phase got %0d expected %0d",
                                    out_data.phase, want.phase));
      end
      frames_seen++;
    end
    if (hold_on) begin
      nst = 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap--;
      nst = 1'b1;
    end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(1, 17) - 1;
      nst      = 1'b1;
    end else begin
      nst = 1'b0;
    end
    out_stall <= nst;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // long receiver hold-off so the pipe fills and in_stall rises
  initial begin : long_hold
    wait (hold_go);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  end

  task automatic queue_word(input logic [1:0] op, input int unsigned s, input int unsigned b);
    in_item_t iw;
    iw.op            = op;
    iw.sender_width  = s[PIXEL_BITS-1:0];
    iw.subject_width = b[PIXEL_BITS-1:0];
    pending_words.push_back(iw);
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_word(OP_TICK, $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [TICK_BITS-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DISPLAY_WIDTH: cur_width    = value[PIXEL_BITS-1:0];
      REG_PAUSE_TICKS:   cur_pause    = value;
      REG_SUBJ_STEP:     cur_bot_step = value;
      REG_SEND_STEP:     cur_top_step = value;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned w, input int unsigned p,
                          input int unsigned bs, input int unsigned ts);
    logic [TICK_BITS-PIXEL_BITS-1:0] junk;
    junk = (TICK_BITS-PIXEL_BITS)'($urandom);
    // upper bits of the width write are don't-care
    write_reg(REG_DISPLAY_WIDTH, {junk, w[PIXEL_BITS-1:0]});
    write_reg(REG_PAUSE_TICKS, p[TICK_BITS-1:0]);
    write_reg(REG_SUBJ_STEP, bs[TICK_BITS-1:0]);
    write_reg(REG_SEND_STEP, ts[TICK_BITS-1:0]);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned w, r, s, b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: display 128 wide
    queue_word(OP_LOAD, 0, 0);
    queue_ticks(1);
    queue_word(OP_UNUSED, 12'hFFF, 12'hFFF);
    queue_word(OP_STOP, 0, 0);
    queue_ticks(1);
    queue_word(OP_LOAD, 12'hFFF, 12'hFFF);
    queue_ticks(2);
    queue_word(OP_STOP, 12'hAAA, 12'h555);
    queue_word(OP_LOAD, 129, 128);
    queue_ticks(1);
    queue_word(OP_LOAD, 128, 129);
    queue_word(OP_LOAD, 128, 128);
    queue_word(OP_LOAD, 12'hAAA, 12'h555);
    queue_word(OP_LOAD, 12'h555, 12'hAAA);
    queue_ticks(1);
    wait_idle();

    // minimum settings: alternation, then a start on full-width lines
    set_regs(1, 1, 1, 1);
    queue_word(OP_LOAD, 1, 1);
    queue_ticks(1);
    queue_word(OP_LOAD, 2, 1);
    queue_ticks(10);
    queue_word(OP_LOAD, 2, 3);
    queue_ticks(24);
    queue_word(OP_LOAD, 4095, 4095);
    queue_ticks(40);
    wait_idle();

    // maximum settings: nothing is wider than the display
    set_regs(4095, 65535, 65535, 65535);
    queue_word(OP_LOAD, 4095, 4095);
    queue_ticks(3);
    queue_word(OP_STOP, 0, 0);
    queue_ticks(1);
    wait_idle();

    // longest pause never runs out here
    set_regs(1, 65535, 2, 2);
    queue_word(OP_LOAD, 3, 3);
    queue_ticks(5);
    wait_idle();

    for (int k = 0; k < 6; k++) begin
      w = $urandom_range(1, 16);
      case (k)
        3:       set_regs(1, 1, 1, 1);
        4:       set_regs(w, $urandom_range(1, 4), 1, 65535);
        default: set_regs(w, $urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(1, 3));
      endcase
      send_idle_en = (k != 1) && (k != 5);
      recv_idle_en = (k != 3) && (k != 5);
      queue_word(OP_LOAD, $urandom_range(0, cur_width + 8), $urandom_range(0, cur_width + 8));
      for (int i = 0; i < 70; i++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          if ($urandom_range(0, 4) == 0) begin
            s = $urandom;
            b = $urandom;
          end else begin
            s = $urandom_range(0, cur_width + 8);
            b = $urandom_range(0, cur_width + 8);
          end
          queue_word(OP_LOAD, s, b);
        end else if (r < 9) begin
          queue_word(OP_STOP, $urandom, $urandom);
        end else if (r < 11) begin
          queue_word(OP_UNUSED, $urandom, $urandom);
        end else begin
          queue_ticks(1);
        end
      end
      if (k == 2) hold_go = 1'b1;
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (expected_frames.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_frames.size()));
    $display("Checked %0d result words for %0d input words in %0d cycles.",
             frames_seen, words_taken, cycle_count);
    $display("Loads: %0d, line wraps: %0d, one %0d-cycle output hold-off.",
             load_count, wrap_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/marq_pkg.sv
rtl/marq_cfg_regs.sv
rtl/marq_core.sv
rtl/two_line_marquee_scroll_sequencer_top.sv
sim/tb.sv
